// ----- rtl/core/srtl_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and widths for the sorted range table lookup
// no dependencies

package srtl_pkg;

    localparam int VALUE_BITS   = 56;
    localparam int COVER_BITS   = VALUE_BITS + 1;
    localparam int COUNT_BITS   = 32;
    localparam int FUNC_BITS    = 2;
    localparam int STATUS_BITS  = 2;
    localparam int DEPTH_DEF    = 256;

    localparam int IN_DATA_BITS  = 3 * VALUE_BITS;
    localparam int OUT_RAW_BITS  = STATUS_BITS + 1 + COUNT_BITS + COVER_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    localparam logic [FUNC_BITS-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_QUERY  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_REPORT = 2'd2;

    localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_INVERTED = 2'd2;

    typedef logic [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        value_t upper;
        value_t lower;
    } range_t;

endpackage

// ----- rtl/core/sorted_range_table_lookup.sv -----
`timescale 1ns / 1ps
// sorted range table: insert, membership query and union length report
// depends on srtl_pkg and srtl_ram
//
// The block holds up to DEPTH inclusive ranges in one memory, kept sorted by
// lower bound, and handles one word at a time. On a non-empty table, a valid
// insert into a non-full table, a query and a report walk that memory at one
// entry per cycle through its single read port. An insert walks the k stored
// ranges with a lower bound above the new one (each is moved up one place).
// A query walks up to the index where the walk stops (first covering range,
// first range above the probe, or the end of the table). A report walks all
// n stored ranges. An inverted range, a full table, any operation on an
// empty table and an unknown code are answered without a walk. The result
// word sits in an output register, so the next input word is taken while the
// result still waits. No clearing pass is needed after reset.

module sorted_range_table_lookup
    import srtl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // range_lower, range_upper, probe
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    // func
    input  logic [FUNC_BITS-1:0]     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // status, hit, hit_count, covered_length, zero fill
    output logic [OUT_DATA_BITS-1:0] m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INS     = 3'd1;
    localparam logic [2:0] ST_INS_LOW = 3'd2;
    localparam logic [2:0] ST_QRY     = 3'd3;
    localparam logic [2:0] ST_RPT     = 3'd4;
    localparam logic [2:0] ST_RPT_END = 3'd5;
    localparam logic [2:0] ST_OUT     = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [COUNT_BITS-1:0]  hits_reg, hits_next;
    logic [AW-1:0]          ptr_reg, ptr_next;
    value_t                 key_lo_reg, key_lo_next;
    value_t                 key_hi_reg, key_hi_next;
    logic [COVER_BITS-1:0]  total_reg, total_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic                   hit_reg, hit_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    logic          accept;
    logic          at_last;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    range_t        wr_data, rd_data;
    value_t        in_lo, in_hi, in_probe;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_lo    = s_tdata[VALUE_BITS-1:0];
    assign in_hi    = s_tdata[2*VALUE_BITS-1:VALUE_BITS];
    assign in_probe = s_tdata[3*VALUE_BITS-1:2*VALUE_BITS];
    assign at_last  = ((CW'(ptr_reg) + CW'(1)) == count_reg);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    srtl_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        hits_next     = hits_reg;
        ptr_next      = ptr_reg;
        key_lo_next   = key_lo_reg;
        key_hi_next   = key_hi_reg;
        total_next    = total_reg;
        status_next   = status_reg;
        hit_next      = hit_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '{upper: key_hi_reg, lower: key_lo_reg};
        rd_en         = 1'b0;
        rd_addr       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = STATUS_OK;
                    hit_next    = 1'b0;
                    total_next  = '0;
                    ptr_next    = '0;
                    key_lo_next = in_lo;
                    key_hi_next = in_hi;
                    state_next  = ST_OUT;
                    priority if (s_tuser == FUNC_INSERT)
                    begin
                        priority if (in_lo > in_hi)
                        begin
                            status_next = STATUS_INVERTED;
                        end
                        else if (count_reg == CW'(DEPTH))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_data    = '{upper: in_hi, lower: in_lo};
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(count_reg - CW'(1));
                            ptr_next   = AW'(count_reg - CW'(1));
                            state_next = ST_INS;
                        end
                    end
                    else if (s_tuser == FUNC_QUERY)
                    begin
                        key_lo_next = in_probe;
                        if (count_reg != '0)
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_QRY;
                        end
                    end
                    else if (s_tuser == FUNC_REPORT)
                    begin
                        if (count_reg != '0)
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_RPT;
                        end
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_INS:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg + AW'(1);
                if (rd_data.lower > key_lo_reg)
                begin
                    wr_data = rd_data;
                    if (ptr_reg == '0)
                    begin
                        state_next = ST_INS_LOW;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = ptr_reg - AW'(1);
                        ptr_next = ptr_reg - AW'(1);
                    end
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = ST_OUT;
                end
            end
            ST_INS_LOW:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                count_next = count_reg + CW'(1);
                state_next = ST_OUT;
            end
            ST_QRY:
            begin
                priority if (key_lo_reg < rd_data.lower)
                begin
                    state_next = ST_OUT;
                end
                else if (key_lo_reg <= rd_data.upper)
                begin
                    hit_next = 1'b1;
                    if (hits_reg != '1)
                    begin
                        hits_next = hits_reg + COUNT_BITS'(1);
                    end
                    state_next = ST_OUT;
                end
                else if (at_last)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + AW'(1);
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            ST_RPT:
            begin
                // key_lo/key_hi hold the run being merged
                priority if (ptr_reg == '0)
                begin
                    key_lo_next = rd_data.lower;
                    key_hi_next = rd_data.upper;
                end
                else if (rd_data.lower <= key_hi_reg)
                begin
                    if (rd_data.upper > key_hi_reg)
                    begin
                        key_hi_next = rd_data.upper;
                    end
                end
                else
                begin
                    total_next  = total_reg + COVER_BITS'(key_hi_reg)
                                - COVER_BITS'(key_lo_reg) + COVER_BITS'(1);
                    key_lo_next = rd_data.lower;
                    key_hi_next = rd_data.upper;
                end
                if (at_last)
                begin
                    state_next = ST_RPT_END;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + AW'(1);
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            ST_RPT_END:
            begin
                total_next = total_reg + COVER_BITS'(key_hi_reg)
                           - COVER_BITS'(key_lo_reg) + COVER_BITS'(1);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_DATA_BITS'({total_reg, hits_reg, hit_reg, status_reg});
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            hits_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            hits_reg     <= hits_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        key_lo_reg  <= key_lo_next;
        key_hi_reg  <= key_hi_next;
        total_reg   <= total_next;
        status_reg  <= status_next;
        hit_reg     <= hit_next;
        m_tdata_reg <= m_tdata_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CW'(1)))
        else $error("entry count moved by other than one");

    a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == ST_INS) || (state_reg == ST_INS_LOW)
                   || (accept && (s_tuser == FUNC_INSERT))))
        else $error("memory written outside an insert");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result word raised outside the output step");

endmodule

// ----- rtl/core/srtl_ram.sv -----
`timescale 1ns / 1ps
// range storage: one write port and one read port with registered read data
// depends on srtl_pkg

module srtl_ram
    import srtl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  range_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output range_t        rd_data
);

    range_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- verif/range_table_checker.sv -----
`timescale 1ns / 1ps
// checker for the sorted range table lookup: mirrors the range table, predicts each answer
// word and compares it with the output channel; depends on srtl_pkg

module range_table_checker
    import srtl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    input  logic [FUNC_BITS-1:0]     s_tuser,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [OUT_DATA_BITS-1:0] m_tdata,
    output int                       mismatches,
    output int                       outstanding
);

    // declared from the top bit down, so status lands in the lowest bits
    typedef struct packed {
        logic [COVER_BITS-1:0]  covered_length;
        logic [COUNT_BITS-1:0]  hit_count;
        logic                   hit;
        logic [STATUS_BITS-1:0] status;
    } answer_t;

    value_t                lower_tab [DEPTH];
    value_t                upper_tab [DEPTH];
    int unsigned           stored    = 0;
    logic [COUNT_BITS-1:0] hit_total = '0;
    answer_t               awaited_answers [$];

    function automatic logic probe_in_table(value_t probe);
        for (int i = 0; i < stored; i++)
        begin
            if (probe < lower_tab[i])
                return 1'b0;
            if (probe <= upper_tab[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [COVER_BITS-1:0] union_size();
        logic [COVER_BITS-1:0] total;
        value_t                lo;
        value_t                hi;
        total = '0;
        if (stored == 0)
            return '0;
        lo = lower_tab[0];
        hi = upper_tab[0];
        for (int i = 1; i < stored; i++)
        begin
            if (lower_tab[i] <= hi)
            begin
                if (upper_tab[i] > hi)
                    hi = upper_tab[i];
            end
            else
            begin
                total = total + {1'b0, hi - lo} + 1'b1;
                lo = lower_tab[i];
                hi = upper_tab[i];
            end
        end
        return total + {1'b0, hi - lo} + 1'b1;
    endfunction

    function automatic answer_t apply_table_op(logic [FUNC_BITS-1:0] fn, value_t lo,
                                               value_t hi, value_t probe);
        answer_t     ans;
        int unsigned pos;
        ans = '0;
        case (fn)
            FUNC_INSERT:
            begin
                if (lo > hi)
                    ans.status = STATUS_INVERTED;
                else if (stored >= DEPTH)
                    ans.status = STATUS_FULL;
                else
                begin
                    // equal lower bounds keep arrival order
                    pos = stored;
                    while (pos > 0 && lower_tab[pos-1] > lo)
                    begin
                        lower_tab[pos] = lower_tab[pos-1];
                        upper_tab[pos] = upper_tab[pos-1];
                        pos--;
                    end
                    lower_tab[pos] = lo;
                    upper_tab[pos] = hi;
                    stored++;
                    ans.status = STATUS_OK;
                end
            end
            FUNC_QUERY:
            begin
                if (probe_in_table(probe))
                begin
                    ans.hit = 1'b1;
                    if (hit_total != '1)
                        hit_total++;
                end
            end
            FUNC_REPORT:
                ans.covered_length = union_size();
            default:
                ;
        endcase
        ans.hit_count = hit_total;
        return ans;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want_v, got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        answer_t want;
        answer_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                awaited_answers.push_back(apply_table_op(s_tuser,
                    s_tdata[VALUE_BITS-1:0],
                    s_tdata[2*VALUE_BITS-1:VALUE_BITS],
                    s_tdata[3*VALUE_BITS-1:2*VALUE_BITS]));
            if (m_tvalid && m_tready)
            begin
                got = answer_t'(m_tdata[OUT_RAW_BITS-1:0]);
                if (awaited_answers.size() == 0)
                begin
                    $display("%0t: word %h arrived with none expected", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("hit", want.hit, got.hit);
                    check_field("hit_count", want.hit_count, got.hit_count);
                    check_field("covered_length", want.covered_length, got.covered_length);
                    check_field("zero fill", 0, m_tdata[OUT_DATA_BITS-1:OUT_RAW_BITS]);
                end
            end
            outstanding = awaited_answers.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// top of the sorted range table lookup testbench: clock, reset, stimulus and verdict
// depends on srtl_pkg, sorted_range_table_lookup and range_table_checker

module testbench;
    import srtl_pkg::*;

    localparam int                   DEPTH          = DEPTH_DEF;
    localparam logic [FUNC_BITS-1:0] FUNC_UNUSED    = 2'd3;
    localparam value_t               VALUE_MAX      = '1;
    localparam int                   RANDOM_WORDS   = 1500;
    localparam int                   PHASE_WORDS    = 150;
    localparam int                   HOLDOFF_CYCLES = 3000;
    localparam int                   DRAIN_CYCLES   = 300;
    localparam int unsigned          CYCLE_LIMIT    = 2_500_000;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic [FUNC_BITS-1:0]     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;

    int          mismatches;
    int          outstanding;
    int unsigned cycle_count    = 0;
    int          words_sent     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned filled         = 0;

    sorted_range_table_lookup #(.DEPTH(DEPTH)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    range_table_checker #(.DEPTH(DEPTH)) answer_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    function automatic value_t any_value();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 6)
            return value_t'($urandom_range(20000));
        if (r < 8)
            return VALUE_MAX - value_t'($urandom_range(20000));
        return value_t'({$urandom, $urandom});
    endfunction

    function automatic value_t span_end(value_t lo);
        value_t      len;
        int unsigned r;
        r = $urandom_range(9);
        if (r < 7)
            len = value_t'($urandom_range(500));
        else if (r < 9)
            len = value_t'($urandom_range(100000));
        else
            len = any_value();
        return (VALUE_MAX - lo < len) ? VALUE_MAX : lo + len;
    endfunction

    task automatic offer_word(input logic [FUNC_BITS-1:0] fn, input value_t lo, hi, pr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {pr, hi, lo};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        if (fn == FUNC_INSERT && lo <= hi && filled < DEPTH)
            filled++;
    endtask

    task automatic offer_random_word();
        int unsigned pick;
        value_t      lo;
        value_t      hi;
        value_t      pr;
        pick = $urandom_range(99);
        lo   = any_value();
        hi   = span_end(lo);
        pr   = any_value();
        if (pick < 28)
        begin
            if ($urandom_range(99) < 12)
            begin
                hi = any_value();
                if (hi == VALUE_MAX)
                    hi = VALUE_MAX - 1;
                lo = hi + 1;
                if ($urandom_range(1) == 1 && lo < VALUE_MAX - 1000)
                    lo = lo + value_t'($urandom_range(1000));
            end
            else if (filled == DEPTH - 1)
            begin
                // last free slot takes the whole value space
                lo = '0;
                hi = VALUE_MAX;
            end
            offer_word(FUNC_INSERT, lo, hi, pr);
        end
        else if (pick < 84)
            offer_word(FUNC_QUERY, lo, hi, pr);
        else if (pick < 97)
            offer_word(FUNC_REPORT, lo, hi, pr);
        else
            offer_word(FUNC_UNUSED, lo, hi, pr);
    endtask

    initial
    begin : receiver
        int unsigned holdoff_left;
        bit          holdoff_done;
        holdoff_left = 0;
        holdoff_done = 1'b0;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            // one long stall so the block backs up into its input
            if (!holdoff_done && words_sent >= 40)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left != 0)
            begin
                holdoff_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : stimulus
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = FUNC_INSERT;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        offer_word(FUNC_QUERY, '0, '0, '0);
        offer_word(FUNC_REPORT, '0, '0, '0);
        offer_word(FUNC_UNUSED, VALUE_MAX, VALUE_MAX, VALUE_MAX);
        offer_word(FUNC_INSERT, VALUE_MAX, '0, '0);
        // extremes
        offer_word(FUNC_INSERT, '0, '0, VALUE_MAX);
        offer_word(FUNC_INSERT, VALUE_MAX, VALUE_MAX, '0);
        offer_word(FUNC_QUERY, VALUE_MAX, '0, '0);
        offer_word(FUNC_QUERY, '0, VALUE_MAX, VALUE_MAX);
        offer_word(FUNC_QUERY, '0, '0, 1);
        offer_word(FUNC_REPORT, '0, '0, '0);
        // overlapping, equal lower and adjacent ranges
        offer_word(FUNC_INSERT, 100, 200, '0);
        offer_word(FUNC_INSERT, 150, 300, '0);
        offer_word(FUNC_INSERT, 100, 120, '0);
        offer_word(FUNC_INSERT, 301, 400, '0);
        offer_word(FUNC_INSERT, 50, 60, '0);
        offer_word(FUNC_QUERY, '0, '0, 55);
        offer_word(FUNC_QUERY, '0, '0, 99);
        offer_word(FUNC_QUERY, '0, '0, 350);
        offer_word(FUNC_QUERY, '0, '0, 401);
        offer_word(FUNC_REPORT, '0, '0, '0);
        offer_word(FUNC_INSERT, 5, 4, '0);
        offer_word(FUNC_UNUSED, '0, '0, 55);
        offer_word(FUNC_QUERY, '0, '0, VALUE_MAX - 1);
        offer_word(FUNC_REPORT, '0, '0, '0);

        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            case ((k / PHASE_WORDS) % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 62;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 62;
                end
                default:
                begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 25;
                end
            endcase
            offer_random_word();
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
